// ----- hw/rtl/mep_pkg.sv -----
// ----------------------------------------------------------------------------
// mep_pkg
// Shared types and constants of the Mandelbrot escape-time pixel engine.
// ----------------------------------------------------------------------------
package mep_pkg;

  // Widths fixed by the transaction fields
  localparam int unsigned ColW      = 11;
  localparam int unsigned IterW     = 6;
  localparam int unsigned ColorW    = 17;
  localparam int unsigned AddrW     = 25;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  // Parameter defaults
  localparam int unsigned MaxIterDefault  = 31;
  localparam int unsigned FracBitsDefault = 28;

  // Register reset values
  localparam logic signed [31:0] CentreRealRst = -32'sd201326592;
  localparam logic signed [31:0] CentreImagRst = 32'sd0;
  localparam logic [30:0]        PixelStepRst  = 31'd1610613;
  localparam logic [11:0]        ImageColsRst  = 12'd512;
  localparam logic [11:0]        ImageRowsRst  = 12'd320;
  localparam logic [11:0]        OriginColRst  = 12'd80;
  localparam logic [11:0]        OriginRowRst  = 12'd80;
  localparam logic [12:0]        LinePitchRst  = 13'd1280;

  // Saturation limits of a plane coordinate
  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7fff_ffff;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    RegCentreReal = 3'd0,
    RegCentreImag = 3'd1,
    RegPixelStep  = 3'd2,
    RegImageCols  = 3'd3,
    RegImageRows  = 3'd4,
    RegOriginCol  = 3'd5,
    RegOriginRow  = 3'd6,
    RegLinePitch  = 3'd7
  } mep_reg_e;

  typedef struct packed {
    logic [ColW-1:0] pixel_col;
    logic [ColW-1:0] pixel_row;
  } mep_in_t;

  typedef struct packed {
    logic [IterW-1:0]  iterations;
    logic [ColorW-1:0] pixel_color;
    logic [AddrW-1:0]  frame_address;
  } mep_out_t;

  // Per-pixel sideband carried along the cell chain
  typedef struct packed {
    logic                     active;
    logic [IterW-1:0]         iter;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic [AddrW-1:0]         frame_address;
  } mep_tag_t;

endpackage

// ----- hw/rtl/mep_front.sv -----
// ----------------------------------------------------------------------------
// mep_front
// Register file, plane coordinate and frame address of an accepted pixel.
// ----------------------------------------------------------------------------
module mep_front import mep_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                accept_i,
  input  mep_in_t             pixel_i,
  output logic                valid_o,
  output mep_tag_t            tag_o
);

  logic signed [31:0] centre_real_q, centre_imag_q;
  logic [30:0]        pixel_step_q;
  logic [11:0]        image_cols_q, image_rows_q, origin_col_q, origin_row_q;
  logic [12:0]        line_pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_real_q <= CentreRealRst;
      centre_imag_q <= CentreImagRst;
      pixel_step_q  <= PixelStepRst;
      image_cols_q  <= ImageColsRst;
      image_rows_q  <= ImageRowsRst;
      origin_col_q  <= OriginColRst;
      origin_row_q  <= OriginRowRst;
      line_pitch_q  <= LinePitchRst;
    end else if (cfg_we_i) begin
      case (mep_reg_e'(cfg_idx_i))
        RegCentreReal: centre_real_q <= $signed(cfg_data_i[31:0]);
        RegCentreImag: centre_imag_q <= $signed(cfg_data_i[31:0]);
        RegPixelStep:  pixel_step_q  <= cfg_data_i[30:0];
        RegImageCols:  image_cols_q  <= cfg_data_i[11:0];
        RegImageRows:  image_rows_q  <= cfg_data_i[11:0];
        RegOriginCol:  origin_col_q  <= cfg_data_i[11:0];
        RegOriginRow:  origin_row_q  <= cfg_data_i[11:0];
        RegLinePitch:  line_pitch_q  <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Stage 0: offsets from the image centre, scaled by the pixel step, and the origin-shifted row and column
  logic signed [11:0] dx, dy;
  logic signed [43:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic [12:0]        row_sum_d, col_sum_d, row_sum_q, col_sum_q;
  logic               valid0_q;

  always_comb begin
    dx        = $signed({1'b0, pixel_i.pixel_col}) - $signed({1'b0, image_cols_q[11:1]});
    dy        = $signed({1'b0, pixel_i.pixel_row}) - $signed({1'b0, image_rows_q[11:1]});
    prod_x_d  = 44'(dx) * 44'($signed({1'b0, pixel_step_q}));
    prod_y_d  = 44'(dy) * 44'($signed({1'b0, pixel_step_q}));
    row_sum_d = {1'b0, origin_row_q} + {2'b0, pixel_i.pixel_row};
    col_sum_d = {1'b0, origin_col_q} + {2'b0, pixel_i.pixel_col};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else begin
      valid0_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_x_q  <= prod_x_d;
    prod_y_q  <= prod_y_d;
    row_sum_q <= row_sum_d;
    col_sum_q <= col_sum_d;
  end

  // Stage 1: add the centre, saturate, form the frame address
  logic signed [44:0] sum_x, sum_y;
  logic [25:0]        addr_full;
  mep_tag_t           tag_d, tag_q;
  logic               valid1_q;

  always_comb begin
    sum_x     = 45'(centre_real_q) + 45'(prod_x_q);
    sum_y     = 45'(centre_imag_q) + 45'(prod_y_q);
    addr_full = {13'd0, row_sum_q} * {13'd0, line_pitch_q} + {13'd0, col_sum_q};
    tag_d               = '0;
    tag_d.active        = 1'b1;
    tag_d.iter          = '0;
    tag_d.frame_address = addr_full[AddrW-1:0];
    if ((&sum_x[44:31]) || !(|sum_x[44:31])) begin
      tag_d.cx = sum_x[31:0];
    end else begin
      tag_d.cx = sum_x[44] ? CoordMin : CoordMax;
    end
    if ((&sum_y[44:31]) || !(|sum_y[44:31])) begin
      tag_d.cy = sum_y[31:0];
    end else begin
      tag_d.cy = sum_y[44] ? CoordMin : CoordMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else begin
      valid1_q <= valid0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  assign valid_o = valid1_q;
  assign tag_o   = tag_q;

endmodule

// ----- hw/rtl/mep_cell.sv -----
// ----------------------------------------------------------------------------
// mep_cell
// One iteration z = z*z + c with escape test, split over two stages.
// ----------------------------------------------------------------------------
module mep_cell import mep_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault,
  parameter int unsigned ZWidth   = FracBitsDefault + 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  mep_tag_t                 tag_i,
  input  logic signed [ZWidth-1:0] zx_i,
  input  logic signed [ZWidth-1:0] zy_i,
  output logic                     valid_o,
  output mep_tag_t                 tag_o,
  output logic signed [ZWidth-1:0] zx_o,
  output logic signed [ZWidth-1:0] zy_o
);

  localparam int unsigned MagW = FracBits + 1;
  localparam int unsigned SqW  = 2 * FracBits + 2;

  // Stage A: magnitudes and products
  logic [ZWidth-1:0] abs_x, abs_y;
  logic [MagW-1:0]   mag_x, mag_y;
  logic [SqW-1:0]    sx_d, sy_d, pxy_d, sx_q, sy_q, pxy_q;
  logic              big_d, big_q, neg_xy_q, valid_a_q;
  mep_tag_t          tag_a_q;

  always_comb begin
    abs_x = zx_i[ZWidth-1] ? ZWidth'(-zx_i) : ZWidth'(zx_i);
    abs_y = zy_i[ZWidth-1] ? ZWidth'(-zy_i) : ZWidth'(zy_i);
    mag_x = abs_x[MagW-1:0];
    mag_y = abs_y[MagW-1:0];
    // A component of magnitude 2.0 or more has escaped on its own
    big_d = (|abs_x[ZWidth-1:MagW]) || (|abs_y[ZWidth-1:MagW]);
    sx_d  = SqW'(mag_x) * SqW'(mag_x);
    sy_d  = SqW'(mag_y) * SqW'(mag_y);
    pxy_d = SqW'(mag_x) * SqW'(mag_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_a_q  <= tag_i;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    pxy_q    <= pxy_d;
    big_q    <= big_d;
    neg_xy_q <= zx_i[ZWidth-1] ^ zy_i[ZWidth-1];
  end

  // Stage B: escape test and update
  logic [SqW:0]               sum_sq;
  logic signed [SqW:0]        diff;
  logic signed [SqW+1:0]      xy2, xy_s;
  logic signed [FracBits+2:0] re_sh;
  logic signed [FracBits+3:0] im_sh;
  logic                       go;
  mep_tag_t                   tag_d, tag_q;
  logic signed [ZWidth-1:0]   zx_d, zy_d, zx_q, zy_q;

  always_comb begin
    sum_sq = {1'b0, sx_q} + {1'b0, sy_q};
    diff   = $signed({1'b0, sx_q}) - $signed({1'b0, sy_q});
    xy2    = $signed({1'b0, pxy_q, 1'b0});
    xy_s   = neg_xy_q ? -xy2 : xy2;
    // Drop the fraction: floor toward minus infinity
    re_sh  = $signed(diff[SqW:FracBits]);
    im_sh  = $signed(xy_s[SqW+1:FracBits]);
    go     = tag_a_q.active && !(big_q || sum_sq[SqW]);
    zx_d   = ZWidth'(re_sh) + ZWidth'(tag_a_q.cx);
    zy_d   = ZWidth'(im_sh) + ZWidth'(tag_a_q.cy);
    tag_d        = tag_a_q;
    tag_d.active = go;
    if (go) begin
      tag_d.iter = IterW'(tag_a_q.iter + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    zx_q  <= zx_d;
    zy_q  <= zy_d;
  end

  assign tag_o = tag_q;
  assign zx_o  = zx_q;
  assign zy_o  = zy_q;

endmodule

// ----- hw/rtl/mep_shade.sv -----
// ----------------------------------------------------------------------------
// mep_shade
// Color lookup from the escape count and the registered result.
// ----------------------------------------------------------------------------
module mep_shade import mep_pkg::*; #(
  parameter int unsigned MaxIter = MaxIterDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  mep_tag_t tag_i,
  output logic     done_o,
  output mep_out_t result_o
);

  localparam int unsigned TabDepth = 2 ** IterW;

  logic [ColorW-1:0] color_tab [TabDepth];

  // Red ramps over the full count, green over quarter steps
  for (genvar i = 0; i < TabDepth; i++) begin : g_tab
    localparam int unsigned Red   = (i * 256) / MaxIter;
    localparam int unsigned Green = ((i / 4) * 256) / (MaxIter / 4);
    assign color_tab[i] = ColorW'(Red + (Green * 256));
  end

  mep_out_t result_d, result_q;

  always_comb begin
    result_d.iterations    = tag_i.iter;
    result_d.pixel_color   = color_tab[tag_i.iter];
    result_d.frame_address = tag_i.frame_address;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o = result_q;

endmodule

// ----- hw/rtl/mandelbrot_escape_pixel_unit.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_unit
// Throughput: one pixel per cycle; busy_o stays low, the cell chain is fully
// pipelined with one iteration cell (two stages) per possible step.
// done_o pulses for one cycle per transaction; the receiver cannot stall.
// Reset: asynchronous, clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_unit import mep_pkg::*; #(
  parameter int unsigned MaxIter  = MaxIterDefault,
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // pixel command
  input  logic                start_i,
  output logic                busy_o,
  input  mep_in_t             pixel_i,
  // result strobe
  output logic                done_o,
  output mep_out_t            result_o
);

  // One cell per iteration that may run; the cap at MAX_ITER-1 falls out of
  // the chain length, so a pixel still active at the end reports the cap.
  localparam int unsigned NumCells = MaxIter - 1;
  // z components stay below 4 + |c| in magnitude; size them for that bound
  localparam int unsigned ZWidth   = (FracBits + 4 > 33) ? FracBits + 4 : 33;
  // front (2) + cells (2 each) + output register (1)
  localparam int unsigned Latency  = 2 + 2 * NumCells + 1;

  logic accept;

  // The chain never backs up, so a new pixel is taken every cycle
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  logic                     valid_c [NumCells+1];
  mep_tag_t                 tag_c   [NumCells+1];
  logic signed [ZWidth-1:0] zx_c    [NumCells+1];
  logic signed [ZWidth-1:0] zy_c    [NumCells+1];

  // Place the pixel in the plane and compute its frame address
  mep_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .pixel_i    (pixel_i),
    .valid_o    (valid_c[0]),
    .tag_o      (tag_c[0])
  );

  // Every orbit starts at z = 0
  assign zx_c[0] = '0;
  assign zy_c[0] = '0;

  // Advance each pixel one iteration per cell; an escaped pixel rides along
  // inactive with its count frozen.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    mep_cell #(
      .FracBits (FracBits),
      .ZWidth   (ZWidth)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .tag_i   (tag_c[k]),
      .zx_i    (zx_c[k]),
      .zy_i    (zy_c[k]),
      .valid_o (valid_c[k+1]),
      .tag_o   (tag_c[k+1]),
      .zx_o    (zx_c[k+1]),
      .zy_o    (zy_c[k+1])
    );
  end

  // Map the count to a color and register the result transaction
  mep_shade #(
    .MaxIter (MaxIter)
  ) u_shade (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_c[NumCells]),
    .tag_i    (tag_c[NumCells]),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Every accepted pixel produces its result after the fixed latency
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("result missing after pixel acceptance");

  // The count never passes the cap
  a_iter_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.iterations <= IterW'(MaxIter - 1)))
    else $error("iteration count above cap");

  // A pixel that escapes at once gets black
  a_zero_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.iterations == '0) |-> (result_o.pixel_color == '0))
    else $error("nonzero color for zero iterations");

endmodule
